FILE: src/dnle_pkg.sv
// Shared constants for the DNS name label encoder.
package dnle_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned LEN_W = 6;

  localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;
  localparam logic [CHAR_W-1:0] PTR_MARK = 8'hC0;
  localparam logic [CHAR_W-1:0] ZERO_BYTE = 8'h00;

endpackage

FILE: src/dns_name_label_encoder.sv
// Top level of the DNS name label encoder with its label buffer memory.
//
// Usage: the input channel (in_valid, in_stall) takes one character of a dotted
// domain name per request, with in_final_char on the last character. Ordinary
// characters are written into the label memory, up to MAX_LABEL per label. A
// dot with a pending label, or a final ordinary character, starts a replay: a
// length byte, the buffered label bytes read back from the memory, and, after a
// final ordinary character, a zero byte or a two-byte compression pointer. Each
// result request on the output channel (out_valid, out_stall) carries one byte;
// out_run_last marks the last byte of a replay and out_name_done the last byte
// of the name. A replay sends one byte per cycle while out_stall stays low and
// holds in_stall high until its last byte is loaded; the single read port of the
// label memory, read one address ahead of the output register, sets that pace.
// The output register lets the next character enter while the last byte of a
// replay still waits. When the receiver stalls, the byte holds and the replay
// pauses. Reset clears the label length, the truncation flag and the valid
// flag; the memory keeps its contents, which never reach out_byte unwritten.
module dns_name_label_encoder #(
  parameter int unsigned MAX_LABEL = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dnle_pkg::CHAR_W-1:0]      in_name_char,
  input  logic                             in_final_char,
  input  logic                             in_use_pointer,
  input  logic [dnle_pkg::OFFSET_W-1:0]    in_pointer_offset,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dnle_pkg::CHAR_W-1:0]      out_byte,
  output logic                             out_run_last,
  output logic                             out_name_done,
  output logic                             out_label_cut
);

  localparam int unsigned IDX_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam logic [dnle_pkg::LEN_W-1:0] MAX_LEN = dnle_pkg::LEN_W'(MAX_LABEL);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA,
    ST_TERM0,
    ST_TERM1
  } state_t;

  state_t                          state_r;
  logic [dnle_pkg::LEN_W-1:0]      len_r;
  logic                            cut_r;
  logic                            term_r;
  logic                            fin_r;
  logic                            ptr_r;
  logic [dnle_pkg::OFFSET_W-1:0]   off_r;
  logic [IDX_W-1:0]                rd_idx_r;
  logic [IDX_W-1:0]                rd_idx_nxt;
  logic [dnle_pkg::CHAR_W-1:0]     rdata_r;
  logic [dnle_pkg::CHAR_W-1:0]     label_mem [MAX_LABEL];

  logic                            out_valid_r;
  logic [dnle_pkg::CHAR_W-1:0]     out_byte_r;
  logic                            out_run_last_r;
  logic                            out_name_done_r;
  logic                            out_label_cut_r;

  logic             accept;
  logic             is_dot;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             load;
  logic             last_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign is_dot    = (in_name_char == dnle_pkg::DOT_CHAR);
  assign wr_en     = accept && !is_dot && (len_r < MAX_LEN);
  assign wr_idx    = len_r[IDX_W-1:0];
  assign load      = !out_valid_r || !out_stall;
  assign last_data = (dnle_pkg::LEN_W'(rd_idx_r) == (len_r - dnle_pkg::LEN_W'(1)));

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (state_r == ST_IDLE) begin
      rd_idx_nxt = '0;
    end else if ((state_r == ST_DATA) && load) begin
      rd_idx_nxt = last_data ? '0 : rd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      label_mem[wr_idx] <= in_name_char;
    end
    if (wr_en && (wr_idx == rd_idx_nxt)) begin
      rdata_r <= in_name_char;
    end else begin
      rdata_r <= label_mem[rd_idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      cut_r       <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      if (out_valid_r && !out_stall && (state_r == ST_IDLE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (is_dot) begin
              term_r <= 1'b0;
              fin_r  <= in_final_char;
              if (len_r != '0) begin
                state_r <= ST_LEN;
              end
            end else begin
              if (len_r < MAX_LEN) begin
                len_r <= len_r + dnle_pkg::LEN_W'(1);
              end else begin
                cut_r <= 1'b1;
              end
              term_r <= 1'b1;
              fin_r  <= 1'b1;
              ptr_r  <= in_use_pointer;
              off_r  <= in_pointer_offset;
              if (in_final_char) begin
                state_r <= ST_LEN;
              end
            end
          end
        end
        ST_LEN: begin
          if (load) begin
            out_valid_r     <= 1'b1;
            out_byte_r      <= dnle_pkg::CHAR_W'(len_r);
            out_run_last_r  <= 1'b0;
            out_name_done_r <= 1'b0;
            out_label_cut_r <= cut_r;
            state_r         <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (load) begin
            out_valid_r     <= 1'b1;
            out_byte_r      <= rdata_r;
            out_run_last_r  <= 1'b0;
            out_name_done_r <= 1'b0;
            out_label_cut_r <= cut_r;
            if (last_data) begin
              if (term_r) begin
                state_r <= ST_TERM0;
              end else begin
                out_run_last_r  <= 1'b1;
                out_name_done_r <= fin_r;
                len_r           <= '0;
                cut_r           <= 1'b0;
                state_r         <= ST_IDLE;
              end
            end
          end
        end
        ST_TERM0: begin
          if (load) begin
            out_valid_r     <= 1'b1;
            out_label_cut_r <= cut_r;
            if (ptr_r) begin
              out_byte_r      <= dnle_pkg::PTR_MARK |
                                 dnle_pkg::CHAR_W'(off_r[dnle_pkg::OFFSET_W-1:8]);
              out_run_last_r  <= 1'b0;
              out_name_done_r <= 1'b0;
              state_r         <= ST_TERM1;
            end else begin
              out_byte_r      <= dnle_pkg::ZERO_BYTE;
              out_run_last_r  <= 1'b1;
              out_name_done_r <= 1'b1;
              len_r           <= '0;
              cut_r           <= 1'b0;
              state_r         <= ST_IDLE;
            end
          end
        end
        ST_TERM1: begin
          if (load) begin
            out_valid_r     <= 1'b1;
            out_byte_r      <= off_r[7:0];
            out_run_last_r  <= 1'b1;
            out_name_done_r <= 1'b1;
            out_label_cut_r <= cut_r;
            len_r           <= '0;
            cut_r           <= 1'b0;
            state_r         <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_name_done = out_name_done_r;
  assign out_label_cut = out_label_cut_r;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the DNS name label encoder.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_LABEL = 32;
  localparam int N_DIR = 19;

  typedef struct packed {
    logic [dnle_pkg::CHAR_W-1:0] data;
    logic                        run_last;
    logic                        name_done;
    logic                        label_cut;
  } enc_byte_t;

  typedef struct packed {
    logic [dnle_pkg::CHAR_W-1:0]   ch;
    logic                          fin;
    logic                          ptr;
    logic [dnle_pkg::OFFSET_W-1:0] off;
    logic                          lit;
    logic [2:0]                    n;
    logic [43:0]                   words;
  } dir_row_t;

  // Literal rows list their bytes in order as {data, run_last, name_done, label_cut}.
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{8'h61, 1'b1, 1'b0, 14'h0000, 1'b1, 3'd3,
      {8'h01, 3'b000, 8'h61, 3'b000, 8'h00, 3'b110, 11'h0}},
    '{8'h2E, 1'b1, 1'b0, 14'h0000, 1'b1, 3'd0, 44'h0},
    '{8'h2E, 1'b0, 1'b1, 14'h3FFF, 1'b1, 3'd0, 44'h0},
    '{8'h78, 1'b1, 1'b1, 14'h3FFF, 1'b1, 3'd4,
      {8'h01, 3'b000, 8'h78, 3'b000, 8'hFF, 3'b000, 8'hFF, 3'b110}},
    '{8'h7A, 1'b1, 1'b1, 14'h0000, 1'b1, 3'd4,
      {8'h01, 3'b000, 8'h7A, 3'b000, 8'hC0, 3'b000, 8'h00, 3'b110}},
    '{8'h00, 1'b0, 1'b1, 14'h3FFF, 1'b1, 3'd0, 44'h0},
    '{8'hFF, 1'b0, 1'b0, 14'h0000, 1'b1, 3'd0, 44'h0},
    '{8'h2E, 1'b0, 1'b0, 14'h1555, 1'b0, 3'd0, 44'h0},
    '{8'h2E, 1'b0, 1'b0, 14'h2AAA, 1'b1, 3'd0, 44'h0},
    '{8'h71, 1'b0, 1'b1, 14'h0000, 1'b1, 3'd0, 44'h0},
    '{8'h2E, 1'b1, 1'b1, 14'h3FFF, 1'b0, 3'd0, 44'h0},
    '{8'h62, 1'b0, 1'b0, 14'h0000, 1'b1, 3'd0, 44'h0},
    '{8'h2E, 1'b0, 1'b0, 14'h0000, 1'b0, 3'd0, 44'h0},
    '{8'h2E, 1'b0, 1'b0, 14'h0000, 1'b1, 3'd0, 44'h0},
    '{8'h63, 1'b1, 1'b1, 14'h1234, 1'b0, 3'd0, 44'h0},
    '{8'h2E, 1'b1, 1'b0, 14'h0000, 1'b1, 3'd0, 44'h0},
    '{8'h41, 1'b1, 1'b0, 14'h0000, 1'b0, 3'd0, 44'h0},
    '{8'h80, 1'b0, 1'b0, 14'h0000, 1'b1, 3'd0, 44'h0},
    '{8'h7F, 1'b1, 1'b1, 14'h2AAA, 1'b0, 3'd0, 44'h0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [dnle_pkg::CHAR_W-1:0]   in_name_char;
  logic                          in_final_char;
  logic                          in_use_pointer;
  logic [dnle_pkg::OFFSET_W-1:0] in_pointer_offset;
  logic                          out_valid;
  logic                          out_stall;
  logic [dnle_pkg::CHAR_W-1:0]   out_byte;
  logic                          out_run_last;
  logic                          out_name_done;
  logic                          out_label_cut;

  dns_name_label_encoder #(
    .MAX_LABEL(MAX_LABEL)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_name_char(in_name_char),
    .in_final_char(in_final_char),
    .in_use_pointer(in_use_pointer),
    .in_pointer_offset(in_pointer_offset),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_run_last(out_run_last),
    .out_name_done(out_name_done),
    .out_label_cut(out_label_cut)
  );

  logic [dnle_pkg::CHAR_W-1:0] lbl_buf [MAX_LABEL];
  logic [dnle_pkg::LEN_W-1:0]  lbl_len;
  logic                        lbl_cut;
  enc_byte_t                   run_bytes [$];
  enc_byte_t                   exp_bytes [$];
  int                          errors;
  int                          sent_count;
  bit                          quiet;
  bit                          long_hold;

  function automatic void add_byte(input logic [dnle_pkg::CHAR_W-1:0] data);
    enc_byte_t b;
    b.data = data;
    b.run_last = 1'b0;
    b.name_done = 1'b0;
    b.label_cut = lbl_cut;
    run_bytes = {run_bytes, b};
  endfunction

  function automatic void replay_label();
    add_byte({2'b00, lbl_len});
    for (int i = 0; i < int'(lbl_len); i++) add_byte(lbl_buf[i]);
  endfunction

  function automatic void encode_char(input logic [dnle_pkg::CHAR_W-1:0] ch,
                                      input logic fin, input logic ptr,
                                      input logic [dnle_pkg::OFFSET_W-1:0] off);
    run_bytes.delete();
    if (ch == dnle_pkg::DOT_CHAR) begin
      if (lbl_len != 0) begin
        replay_label();
        lbl_len = '0;
        lbl_cut = 1'b0;
      end
    end else begin
      if (int'(lbl_len) < MAX_LABEL) begin
        lbl_buf[lbl_len] = ch;
        lbl_len = lbl_len + 1'b1;
      end else begin
        lbl_cut = 1'b1;
      end
      if (fin) begin
        replay_label();
        if (ptr) begin
          add_byte(dnle_pkg::PTR_MARK | {2'b00, off[13:8]});
          add_byte(off[7:0]);
        end else begin
          add_byte(dnle_pkg::ZERO_BYTE);
        end
      end
    end
    if (fin) begin
      lbl_len = '0;
      lbl_cut = 1'b0;
    end
    if (run_bytes.size() != 0) begin
      run_bytes[run_bytes.size()-1].run_last = 1'b1;
      run_bytes[run_bytes.size()-1].name_done = fin;
    end
  endfunction

  task automatic send_req(input logic [dnle_pkg::CHAR_W-1:0] ch, input logic fin,
                          input logic ptr, input logic [dnle_pkg::OFFSET_W-1:0] off,
                          input logic lit, input logic [2:0] n,
                          input logic [43:0] words);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_name_char <= ch;
    in_final_char <= fin;
    in_use_pointer <= ptr;
    in_pointer_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    encode_char(ch, fin, ptr, off);
    if (lit) begin
      for (int k = 0; k < int'(n); k++) begin
        exp_bytes = {exp_bytes, enc_byte_t'(words[43-k*11 -: 11])};
      end
    end else begin
      foreach (run_bytes[k]) exp_bytes = {exp_bytes, run_bytes[k]};
    end
  endtask

  function automatic logic [dnle_pkg::CHAR_W-1:0] label_char();
    logic [dnle_pkg::CHAR_W-1:0] ch;
    do ch = dnle_pkg::CHAR_W'($urandom_range(0, 255)); while (ch == dnle_pkg::DOT_CHAR);
    return ch;
  endfunction

  function automatic logic [dnle_pkg::OFFSET_W-1:0] rand_offset();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return dnle_pkg::OFFSET_W'($urandom_range(0, 16383));
    endcase
  endfunction

  task automatic send_name(input bit force_long);
    int nlab;
    int len;
    bit dot_end;
    logic ptr;
    nlab = $urandom_range(1, 4);
    dot_end = ($urandom_range(0, 4) == 0);
    ptr = 1'($urandom_range(0, 1));
    for (int l = 0; l < nlab; l++) begin
      case ($urandom_range(0, 11))
        0: len = 0;
        1: len = $urandom_range(MAX_LABEL - 2, MAX_LABEL + 6);
        default: len = $urandom_range(1, 8);
      endcase
      if (force_long && l == 0) len = MAX_LABEL + 3;
      if (l == nlab - 1 && !dot_end && len == 0) len = 1;
      for (int c = 0; c < len; c++) begin
        send_req(label_char(), (l == nlab - 1 && !dot_end && c == len - 1), ptr,
                 rand_offset(), 1'b0, 3'd0, 44'h0);
      end
      if (l != nlab - 1 || dot_end) begin
        send_req(dnle_pkg::DOT_CHAR, (l == nlab - 1), 1'($urandom_range(0, 1)),
                 rand_offset(), 1'b0, 3'd0, 44'h0);
      end
    end
  endtask

  task automatic send_noise();
    int cnt;
    logic [dnle_pkg::CHAR_W-1:0] ch;
    cnt = $urandom_range(1, 6);
    for (int i = 0; i < cnt; i++) begin
      ch = ($urandom_range(0, 2) == 0) ? dnle_pkg::DOT_CHAR :
           dnle_pkg::CHAR_W'($urandom_range(0, 255));
      send_req(ch, ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)), rand_offset(),
               1'b0, 3'd0, 44'h0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #7_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int s;
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        s = 1;
        n = 400;
      end else if (quiet) begin
        s = 0;
        n = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        s = 1;
        n = $urandom_range(1, 14);
      end else begin
        s = 0;
        n = $urandom_range(1, 20);
      end
      @(negedge clk);
      out_stall <= s[0];
      repeat (n - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    enc_byte_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_bytes.size() == 0) begin
        $error("unexpected result request: out_byte %h", out_byte);
        errors++;
      end else begin
        e = exp_bytes.pop_front();
        if (out_byte !== e.data) begin
          $error("out_byte: expected %h, actual %h", e.data, out_byte);
          errors++;
        end
        if (out_run_last !== e.run_last) begin
          $error("out_run_last: expected %b, actual %b", e.run_last, out_run_last);
          errors++;
        end
        if (out_name_done !== e.name_done) begin
          $error("out_name_done: expected %b, actual %b", e.name_done, out_name_done);
          errors++;
        end
        if (out_label_cut !== e.label_cut) begin
          $error("out_label_cut: expected %b, actual %b", e.label_cut, out_label_cut);
          errors++;
        end
      end
    end
  end

  initial begin
    bit hold_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_name_char = '0;
    in_final_char = 1'b0;
    in_use_pointer = 1'b0;
    in_pointer_offset = '0;
    errors = 0;
    sent_count = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    hold_done = 1'b0;
    lbl_len = '0;
    lbl_cut = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      send_req(DIR_TAB[r].ch, DIR_TAB[r].fin, DIR_TAB[r].ptr, DIR_TAB[r].off,
               DIR_TAB[r].lit, DIR_TAB[r].n, DIR_TAB[r].words);
    end

    // Let the block drain completely before the random traffic starts.
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    send_name(1'b1);

    while (sent_count < 310) begin
      if (!hold_done && sent_count >= 120) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (sent_count >= 260) quiet = 1'b1;
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_name(1'b0);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/dnle_pkg.sv
src/dns_name_label_encoder.sv
dv/tb.sv
